### rtl/core/qpe_pkg.sv
// Shared types, character codes and helper functions of the quoted-printable encoder.
package qpe_pkg;

	typedef logic [7:0] qpe_byte_t;

	// longest encoded run for one input byte: soft break plus an escape
	localparam int unsigned SeqDepth = 6;
	localparam int unsigned CntWidth = $clog2(SeqDepth + 1);

	typedef logic [CntWidth-1:0] qpe_cnt_t;

	localparam qpe_byte_t MAX_LINE_RESET = 8'd76;

	localparam qpe_byte_t PASS_LO_A = 8'd33;
	localparam qpe_byte_t PASS_HI_A = 8'd60;
	localparam qpe_byte_t PASS_LO_B = 8'd62;
	localparam qpe_byte_t PASS_HI_B = 8'd126;

	localparam qpe_byte_t CH_EQUALS = 8'h3D;
	localparam qpe_byte_t CH_CR     = 8'h0D;
	localparam qpe_byte_t CH_LF     = 8'h0A;
	localparam qpe_byte_t CH_TAB    = 8'h09;
	localparam qpe_byte_t CH_SPACE  = 8'h20;
	localparam qpe_byte_t CH_ZERO   = 8'h30;
	localparam qpe_byte_t CH_UPPER_A = 8'h41;

	localparam qpe_cnt_t CNT_BREAK = qpe_cnt_t'(3);
	localparam qpe_cnt_t CNT_PLAIN = qpe_cnt_t'(1);
	localparam qpe_cnt_t CNT_ESC   = qpe_cnt_t'(3);

	// upper-case hex digit of a nibble
	function automatic qpe_byte_t hex_digit(input logic [3:0] nib);
		qpe_byte_t d;
		if (nib < 4'd10) begin
			d = CH_ZERO + {4'd0, nib};
		end else begin
			d = CH_UPPER_A + {4'd0, nib} - 8'd10;
		end
		return d;
	endfunction

	// bytes that stand for themselves in the encoded text
	function automatic logic passes_through(input qpe_byte_t ch, input logic is_last);
		logic p;
		p = ((ch >= PASS_LO_A) && (ch <= PASS_HI_A)) ||
			((ch >= PASS_LO_B) && (ch <= PASS_HI_B)) ||
			(((ch == CH_TAB) || (ch == CH_SPACE)) && !is_last);
		return p;
	endfunction

endpackage

### rtl/core/qpe_if.sv
// Valid/ready channel interfaces for raw input bytes and encoded output bytes.
interface qpe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, input ready, output data_byte, output first_byte,
		output last_byte);
	modport sink (input valid, output ready, input data_byte, input first_byte,
		input last_byte);
endinterface

interface qpe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;

	modport source (output valid, input ready, output out_byte, output run_last);
	modport sink (input valid, output ready, input out_byte, input run_last);
endinterface

### rtl/core/quoted_printable_encoder_core.sv
// Quoted-printable encoder: one raw byte in, its encoded run of bytes out.
// Latency: the first encoded byte is offered in the cycle after the input transfer.
// Throughput: one output byte per cycle while enc.ready is high; each input byte
//   gives a run of 1, 3, 4 or 6 bytes, drained from the run register by the result channel.
// A new input byte is taken in the same cycle the last byte of the previous run leaves.
// Reset (arst_n low, asynchronous): run empty, line position 0, line limit 76.
module quoted_printable_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	qpe_in_if.sink      raw,
	qpe_out_if.source   enc
);
	import qpe_pkg::*;

	// configuration and line state
	qpe_byte_t max_line_q;
	qpe_byte_t line_pos_q;

	// encoded run: entry 0 is the byte on offer, cnt_q bytes remain
	qpe_byte_t seq_s1 [SeqDepth];
	qpe_cnt_t  cnt_q;

	logic      raw_xfer;
	logic      enc_xfer;

	// encoding of the byte on the input channel
	qpe_byte_t base_pos;
	logic      plain;
	qpe_byte_t width;
	logic      brk;
	qpe_byte_t pay [3];
	qpe_byte_t seq_d [SeqDepth];
	qpe_cnt_t  cnt_d;
	qpe_byte_t pos_d;

	// Offer the head of the run; accept a new byte once the run is empty or
	// its last byte is being transferred this cycle.
	assign enc.valid    = (cnt_q != '0);
	assign enc.out_byte = seq_s1[0];
	assign enc.run_last = (cnt_q == qpe_cnt_t'(1));
	assign enc_xfer     = enc.valid && enc.ready;
	assign raw.ready    = (cnt_q == '0) || (enc_xfer && enc.run_last);
	assign raw_xfer     = raw.valid && raw.ready;

	always_comb begin
		// a first byte restarts the line before the width check
		base_pos = raw.first_byte ? '0 : line_pos_q;
		plain    = passes_through(raw.data_byte, raw.last_byte);
		width    = plain ? 8'd1 : 8'd3;
		brk      = ({1'b0, base_pos} + {1'b0, width}) >= {1'b0, max_line_q};

		if (plain) begin
			pay[0] = raw.data_byte;
			pay[1] = raw.data_byte;
			pay[2] = raw.data_byte;
		end else begin
			pay[0] = CH_EQUALS;
			pay[1] = hex_digit(raw.data_byte[7:4]);
			pay[2] = hex_digit(raw.data_byte[3:0]);
		end

		// soft break '=' CR LF goes ahead of the payload; the break itself
		// does not count towards the line position
		if (brk) begin
			seq_d[0] = CH_EQUALS;
			seq_d[1] = CH_CR;
			seq_d[2] = CH_LF;
			seq_d[3] = pay[0];
			seq_d[4] = pay[1];
			seq_d[5] = pay[2];
			cnt_d    = CNT_BREAK + (plain ? CNT_PLAIN : CNT_ESC);
			pos_d    = width;
		end else begin
			seq_d[0] = pay[0];
			seq_d[1] = pay[1];
			seq_d[2] = pay[2];
			seq_d[3] = pay[0];
			seq_d[4] = pay[1];
			seq_d[5] = pay[2];
			cnt_d    = plain ? CNT_PLAIN : CNT_ESC;
			pos_d    = base_pos + width;
		end
	end

	// control state: run length, line position, line limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			line_pos_q <= '0;
			max_line_q <= MAX_LINE_RESET;
		end else begin
			if (cfg_wr_en) begin
				max_line_q <= cfg_wr_data;
			end
			if (raw_xfer) begin
				cnt_q      <= cnt_d;
				line_pos_q <= pos_d;
			end else if (enc_xfer) begin
				cnt_q <= cnt_q - qpe_cnt_t'(1);
			end
		end
	end

	// run payload: load a fresh run, or advance by one byte per transfer
	always_ff @(posedge clk) begin
		if (raw_xfer) begin
			seq_s1 <= seq_d;
		end else if (enc_xfer) begin
			for (int i = 0; i < SeqDepth - 1; i++) begin
				seq_s1[i] <= seq_s1[i+1];
			end
		end
	end

endmodule

### rtl/core/qpe_checker.sv
// Port-level assertions for the quoted-printable encoder, bound into the encoder core.
module qpe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       raw_valid,
	input logic       raw_ready,
	input logic       enc_valid,
	input logic       enc_ready,
	input logic [7:0] enc_out_byte,
	input logic       enc_run_last
);

	// a stalled output byte holds
	a_enc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		enc_valid && !enc_ready |=> enc_valid && $stable(enc_out_byte) &&
			$stable(enc_run_last))
		else $error("stalled output byte changed");

	// every accepted input offers output in the next cycle
	a_acc_out: assert property (@(posedge clk) disable iff (!arst_n)
		raw_valid && raw_ready |=> enc_valid)
		else $error("accepted input produced no output");

	// no input is taken while more than the last byte of a run is pending
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		enc_valid && !enc_run_last |-> !raw_ready)
		else $error("input accepted mid-run");

	// an idle block is always ready
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!enc_valid |-> raw_ready)
		else $error("idle block not ready");

endmodule

bind quoted_printable_encoder_core qpe_checker u_qpe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.raw_valid    (raw.valid),
	.raw_ready    (raw.ready),
	.enc_valid    (enc.valid),
	.enc_ready    (enc.ready),
	.enc_out_byte (enc.out_byte),
	.enc_run_last (enc.run_last)
);

### verif/tb_quoted_printable_encoder_core.sv
// Self-checking testbench of the quoted-printable encoder core under random flow control.
module tb_quoted_printable_encoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	import qpe_pkg::*;

	// one raw byte as offered on the input channel
	typedef struct packed {
		qpe_byte_t data_byte;
		logic      first_byte;
		logic      last_byte;
	} raw_byte_t;

	// one encoded byte as expected on the output channel
	typedef struct packed {
		qpe_byte_t out_byte;
		logic      run_last;
	} enc_byte_t;

	// receiver back-pressure patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_PERIODIC,
		RX_HEAVY
	} rx_mode_t;

	localparam int unsigned RESET_CYCLES    = 12;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned END_WAIT_CYCLES = 50000;

	// range ends of the literal classes, handy as random picks
	localparam qpe_byte_t BOUNDARY_BYTES [6] = '{
		8'h00, 8'hFF, PASS_LO_A, PASS_HI_A, PASS_LO_B, PASS_HI_B
	};

	// opening sequence: class boundaries, every hex letter, trailing blanks,
	// and first and last marked on the same byte
	localparam raw_byte_t DIRECTED_BYTES [21] = '{
		'{8'h41,     1'b1, 1'b0},
		'{8'h00,     1'b0, 1'b0},
		'{8'hFF,     1'b0, 1'b0},
		'{PASS_LO_A, 1'b0, 1'b0},
		'{PASS_HI_A, 1'b0, 1'b0},
		'{CH_EQUALS, 1'b0, 1'b0},
		'{PASS_LO_B, 1'b0, 1'b0},
		'{PASS_HI_B, 1'b0, 1'b0},
		'{8'h7F,     1'b0, 1'b0},
		'{CH_SPACE,  1'b0, 1'b0},
		'{CH_TAB,    1'b0, 1'b0},
		'{CH_CR,     1'b0, 1'b0},
		'{CH_LF,     1'b0, 1'b0},
		'{8'hAF,     1'b0, 1'b0},
		'{8'hBC,     1'b0, 1'b0},
		'{8'hE9,     1'b0, 1'b0},
		'{CH_SPACE,  1'b0, 1'b1},
		'{CH_TAB,    1'b1, 1'b1},
		'{8'h41,     1'b1, 1'b1},
		'{8'h61,     1'b1, 1'b0},
		'{CH_TAB,    1'b0, 1'b1}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	qpe_in_if  raw_ch ();
	qpe_out_if enc_ch ();

	quoted_printable_encoder_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.raw         (raw_ch),
		.enc         (enc_ch)
	);

	raw_byte_t   raw_pending[$];   // bytes still to be offered
	enc_byte_t   encoded_q[$];     // encoded bytes still owed by the core
	qpe_byte_t   line_limit;       // mirror of the line length register
	qpe_byte_t   line_pos;         // mirror of the encoded line position
	int unsigned mismatch_count;
	int unsigned burst_left;
	int unsigned gap_left;
	rx_mode_t    rx_mode;
	int unsigned rx_mode_left;
	int unsigned rx_tick;
	raw_byte_t   next_raw;
	enc_byte_t   want;
	string       hex_chars = "0123456789ABCDEF";

	// 8 ns clock, low phase first
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void push_enc(qpe_byte_t b, logic tail);
		enc_byte_t e;
		e.out_byte = b;
		e.run_last = tail;
		encoded_q.push_back(e);
	endfunction

	// Work out the encoded run of one accepted byte and advance the line position.
	function automatic void encode_byte(raw_byte_t it);
		logic        literal;
		int unsigned width;
		if (it.first_byte) begin
			line_pos = '0;
		end
		// printable ASCII other than '=' stands for itself; a blank does too,
		// unless it closes the text
		literal = (it.data_byte >= PASS_LO_A && it.data_byte <= PASS_HI_B &&
			it.data_byte != CH_EQUALS) ||
			((it.data_byte == CH_SPACE || it.data_byte == CH_TAB) && !it.last_byte);
		width = literal ? 1 : 3;
		// soft break whenever the next encoding would reach the limit, even on an
		// empty line when the limit is tiny
		if (line_pos + width >= line_limit) begin
			push_enc(CH_EQUALS, 1'b0);
			push_enc(CH_CR, 1'b0);
			push_enc(CH_LF, 1'b0);
			line_pos = '0;
		end
		line_pos = qpe_byte_t'(line_pos + width);
		if (literal) begin
			push_enc(it.data_byte, 1'b1);
		end else begin
			push_enc(CH_EQUALS, 1'b0);
			push_enc(qpe_byte_t'(hex_chars[it.data_byte[7:4]]), 1'b0);
			push_enc(qpe_byte_t'(hex_chars[it.data_byte[3:0]]), 1'b1);
		end
	endfunction

	// Queue texts of random length: first flag on the opening byte, last flag on the
	// closing one. A share of the bytes get random flags to break the framing.
	task automatic queue_texts(int unsigned count, int unsigned min_len,
			int unsigned max_len, int unsigned esc_pct, int unsigned noise_pct);
		raw_byte_t   it;
		int unsigned run_left = 0;
		repeat (count) begin
			it.first_byte = (run_left == 0);
			if (run_left == 0) begin
				run_left = $urandom_range(max_len, min_len);
			end
			it.last_byte = (run_left == 1);
			run_left--;
			if ($urandom_range(99, 0) < esc_pct) begin
				// bytes that need escaping, blanks apart, which pass unless they close the text
				case ($urandom_range(2, 0))
					0: begin
						it.data_byte = qpe_byte_t'($urandom_range(32, 0));
					end
					1: begin
						it.data_byte = CH_EQUALS;
					end
					default: begin
						it.data_byte = qpe_byte_t'($urandom_range(255, 127));
					end
				endcase
			end else begin
				case ($urandom_range(5, 0))
					0, 1: begin
						it.data_byte = qpe_byte_t'($urandom_range(255, 0));
					end
					2: begin
						it.data_byte = $urandom_range(1, 0) ? CH_SPACE : CH_TAB;
					end
					3: begin
						it.data_byte = $urandom_range(1, 0) ? CH_CR : CH_LF;
					end
					4: begin
						it.data_byte = BOUNDARY_BYTES[$urandom_range(5, 0)];
					end
					default: begin
						it.data_byte = qpe_byte_t'($urandom_range(126, 33));
					end
				endcase
			end
			if ($urandom_range(99, 0) < noise_pct) begin
				it.first_byte = 1'($urandom_range(1, 0));
				it.last_byte  = 1'($urandom_range(1, 0));
			end
			raw_pending.push_back(it);
		end
	endtask

	// Hold until every queued byte has gone in and every encoded byte has come out.
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (raw_pending.size() != 0 || raw_ch.valid || encoded_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Change the line limit on an idle core; the sender stays paused meanwhile.
	task automatic write_limit(qpe_byte_t value);
		wait_idle();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		line_limit = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Sender: offer queued bytes in bursts with random gaps between them.
	// Predict at the edge of each transfer so the line position follows the
	// order in which the core takes the bytes.
	always @(posedge clk) begin
		if (!arst_n) begin
			raw_ch.valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (raw_ch.valid && raw_ch.ready) begin
				encode_byte(raw_byte_t'{raw_ch.data_byte, raw_ch.first_byte,
					raw_ch.last_byte});
			end
			// advance only when the channel is free or the held byte just left
			if (!raw_ch.valid || raw_ch.ready) begin
				if (gap_left != 0 || raw_pending.size() == 0) begin
					if (gap_left != 0) begin
						gap_left--;
					end
					raw_ch.valid <= 1'b0;
				end else begin
					next_raw = raw_pending.pop_front();
					raw_ch.data_byte  <= next_raw.data_byte;
					raw_ch.first_byte <= next_raw.first_byte;
					raw_ch.last_byte  <= next_raw.last_byte;
					raw_ch.valid      <= 1'b1;
					if (burst_left == 0) begin
						// a third of the bursts run straight into the next one
						burst_left = $urandom_range(12, 1);
						gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// Receiver: check each transfer against the oldest expectation, then pick the
	// ready level for the next cycle from the current stall pattern.
	always @(posedge clk) begin
		if (!arst_n) begin
			enc_ch.ready <= 1'b0;
			rx_mode      = RX_OPEN;
			rx_mode_left = 0;
			rx_tick      = 0;
		end else begin
			if (enc_ch.valid && enc_ch.ready) begin
				if (encoded_q.size() == 0) begin
					$error("unexpected encoded byte %02h", enc_ch.out_byte);
					mismatch_count++;
				end else begin
					want = encoded_q.pop_front();
					if (enc_ch.out_byte !== want.out_byte) begin
						$error("out_byte: expected %02h, actual %02h",
							want.out_byte, enc_ch.out_byte);
						mismatch_count++;
					end
					if (enc_ch.run_last !== want.run_last) begin
						$error("run_last: expected %0b, actual %0b",
							want.run_last, enc_ch.run_last);
						mismatch_count++;
					end
				end
			end
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(3, 0));
				rx_mode_left = $urandom_range(80, 20);
			end else begin
				rx_mode_left--;
			end
			rx_tick++;
			case (rx_mode)
				RX_OPEN: begin
					enc_ch.ready <= 1'b1;
				end
				RX_LIGHT: begin
					enc_ch.ready <= ($urandom_range(3, 0) != 0);
				end
				RX_PERIODIC: begin
					enc_ch.ready <= (rx_tick % 5 != 0);
				end
				default: begin
					enc_ch.ready <= ($urandom_range(3, 0) == 0);
				end
			endcase
		end
	end

	// Stimulus and end of run.
	initial begin
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = '0;
		raw_ch.valid      = 1'b0;
		raw_ch.data_byte  = '0;
		raw_ch.first_byte = 1'b0;
		raw_ch.last_byte  = 1'b0;
		enc_ch.ready      = 1'b0;
		mismatch_count    = 0;
		line_limit        = MAX_LINE_RESET;
		line_pos          = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset limit: directed bytes, then short random texts
		foreach (DIRECTED_BYTES[i]) begin
			raw_pending.push_back(DIRECTED_BYTES[i]);
		end
		queue_texts(12, 1, 40, 50, 10);

		// smallest legal limit: soft breaks come thick and fast
		write_limit(8'd4);
		queue_texts(10, 1, 8, 40, 15);

		// largest limit: one long escape-heavy text to reach the far end of the line
		write_limit(8'd255);
		queue_texts(100, 100, 200, 80, 0);

		// limits below the legal range: a break even on an empty line
		write_limit(8'd0);
		queue_texts(5, 1, 4, 50, 20);
		write_limit(8'd3);
		queue_texts(5, 1, 4, 50, 20);

		// somewhere in between
		write_limit(qpe_byte_t'($urandom_range(40, 5)));
		queue_texts(7, 1, 30, 40, 10);

		// drain, with a bound, then let the core settle
		for (int unsigned n = 0; n < END_WAIT_CYCLES &&
				(raw_pending.size() != 0 || raw_ch.valid || encoded_q.size() != 0); n++) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (raw_pending.size() != 0 || raw_ch.valid) begin
			$error("%0d raw bytes never accepted", raw_pending.size());
			mismatch_count++;
		end
		if (encoded_q.size() != 0) begin
			$error("%0d encoded bytes never arrived", encoded_q.size());
			mismatch_count++;
		end

		if (mismatch_count == 0) begin
			$display("quoted_printable_encoder_core regression: pass");
		end else begin
			$display("quoted_printable_encoder_core regression: fail");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("quoted_printable_encoder_core regression: fail");
		$finish;
	end

endmodule

### files.f
rtl/core/qpe_pkg.sv
rtl/core/qpe_if.sv
rtl/core/quoted_printable_encoder_core.sv
rtl/core/qpe_checker.sv
verif/tb_quoted_printable_encoder_core.sv
